@@ rtl/lrc_pkg.sv @@
// Shared constants and types for the clipped line rasterizer.
// Has no dependencies; every other rtl file imports it.
package lrc_pkg;

  localparam int WIN_BITS     = 12;
  localparam int COLOR_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_W = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_H = CFG_IDX_BITS'(1);

  localparam logic [WIN_BITS-1:0] WIN_W_RESET = WIN_BITS'(640);
  localparam logic [WIN_BITS-1:0] WIN_H_RESET = WIN_BITS'(480);

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    logic [WIN_BITS-1:0] width;
    logic [WIN_BITS-1:0] height;
  } win_cfg_t;

endpackage

@@ rtl/line_rasterizer_clipped.sv @@
// Clipped Bresenham line rasterizer, top level.
//
// Usage: configure the window width (index 0) and the window height (index 1)
// through cfg_write / cfg_index / cfg_data while the block is idle. Items enter
// on the input channel (in_valid / in_stall); mode 0 loads a line (start, end,
// color) and gives no result, mode 1 asks for the next pixel of the current line.
// Each step of an active line returns one result on the output channel
// (out_valid / out_stall): a drawn pixel, or a drawn = 0 end marker when the
// line leaves the window. last marks the final result of a line. Steps while
// no line is active, and loads of zero-length lines, give nothing.
//
// A step's result is registered: the item is written into the two-entry queue
// and is stepped from there into the output register once the output is free.
// The single add, compare and subtract on the error term lets the stepper take
// one item per cycle while the output is not stalled, so a pixel can leave every
// cycle. When the receiver stalls, the result holds and the queue absorbs up to
// two more items before in_stall rises. Reset clears the queue, the output valid
// flag and the active line, and sets the window to 640 by 480.
module line_rasterizer_clipped #(
  parameter int COORD_BITS = 13
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic        [lrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic        [lrc_pkg::WIN_BITS-1:0]   cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic        [lrc_pkg::COLOR_BITS-1:0] line_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_BITS:0]            pixel_x,
  output logic signed [COORD_BITS:0]            pixel_y,
  output logic        [lrc_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                                  drawn,
  output logic                                  last
);
  import lrc_pkg::*;

  localparam int ENTRY_BITS = 1 + 4 * COORD_BITS + 3 + COLOR_BITS;

  win_cfg_t win;

  logic                         f_load;
  logic        [COORD_BITS-1:0] f_major_len;
  logic        [COORD_BITS-1:0] f_minor_len;
  logic                         f_step_x_neg;
  logic                         f_step_y_neg;
  logic                         f_x_is_major;

  logic [ENTRY_BITS-1:0] wr_data;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;

  logic                         e_load;
  logic signed [COORD_BITS-1:0] e_start_x;
  logic signed [COORD_BITS-1:0] e_start_y;
  logic        [COORD_BITS-1:0] e_major_len;
  logic        [COORD_BITS-1:0] e_minor_len;
  logic                         e_step_x_neg;
  logic                         e_step_y_neg;
  logic                         e_x_is_major;
  logic        [COLOR_BITS-1:0] e_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.width  <= WIN_W_RESET;
      win.height <= WIN_H_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_WIN_W) begin
        win.width <= cfg_data;
      end else if (cfg_index == REG_WIN_H) begin
        win.height <= cfg_data;
      end
    end
  end

  lrc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .mode       (mode),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .load       (f_load),
    .major_len  (f_major_len),
    .minor_len  (f_minor_len),
    .step_x_neg (f_step_x_neg),
    .step_y_neg (f_step_y_neg),
    .x_is_major (f_x_is_major)
  );

  assign in_stall = q_full;
  assign wr_data  = {f_load, start_x, start_y, f_major_len, f_minor_len,
                     f_step_x_neg, f_step_y_neg, f_x_is_major, line_color};

  lrc_queue #(.DATA_BITS(ENTRY_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_valid && !q_full),
    .wr_data   (wr_data),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_data   (rd_data),
    .not_empty (q_valid)
  );

  assign {e_load, e_start_x, e_start_y, e_major_len, e_minor_len,
          e_step_x_neg, e_step_y_neg, e_x_is_major, e_color} = rd_data;

  lrc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .e_load       (e_load),
    .e_start_x    (e_start_x),
    .e_start_y    (e_start_y),
    .e_major_len  (e_major_len),
    .e_minor_len  (e_minor_len),
    .e_step_x_neg (e_step_x_neg),
    .e_step_y_neg (e_step_y_neg),
    .e_x_is_major (e_x_is_major),
    .e_color      (e_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .drawn        (drawn),
    .last         (last)
  );

endmodule

@@ rtl/lrc_front.sv @@
// Front end of the line rasterizer: classifies an incoming item and, for a load,
// works out the axis lengths, directions and major axis. Uses lrc_pkg.
module lrc_front #(
  parameter int COORD_BITS = 13
) (
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         load,
  output logic        [COORD_BITS-1:0] major_len,
  output logic        [COORD_BITS-1:0] minor_len,
  output logic                         step_x_neg,
  output logic                         step_y_neg,
  output logic                         x_is_major
);
  import lrc_pkg::*;

  localparam int DIFF_BITS = COORD_BITS + 1;

  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic        [DIFF_BITS-1:0] dx_mag;
  logic        [DIFF_BITS-1:0] dy_mag;
  logic        [COORD_BITS-1:0] adx;
  logic        [COORD_BITS-1:0] ady;

  always_comb begin
    dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    dx_mag = dx[DIFF_BITS-1] ? -dx : dx;
    dy_mag = dy[DIFF_BITS-1] ? -dy : dy;
    // The magnitude of a difference of two in-range coordinates fits COORD_BITS.
    adx = dx_mag[COORD_BITS-1:0];
    ady = dy_mag[COORD_BITS-1:0];

    load       = (mode == MODE_LOAD);
    // A zero delta counts as a negative direction.
    step_x_neg = dx[DIFF_BITS-1] || (dx == '0);
    step_y_neg = dy[DIFF_BITS-1] || (dy == '0);
    x_is_major = adx > ady;
    major_len  = x_is_major ? adx : ady;
    minor_len  = x_is_major ? ady : adx;
  end

endmodule

@@ rtl/lrc_queue.sv @@
// Two-entry queue between the front end and the stepper of the line rasterizer.
// Uses lrc_pkg for its depth.
module lrc_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output logic [DATA_BITS-1:0] rd_data,
  output logic                 not_empty
);
  import lrc_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;

  assign full      = (count == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lrc_back.sv @@
// Stepper of the line rasterizer: runs the Bresenham walk, tests the window and
// holds the result in an output register. Uses lrc_pkg.
module lrc_back #(
  parameter int COORD_BITS = 13
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lrc_pkg::win_cfg_t                     win,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  logic                                  e_load,
  input  logic signed [COORD_BITS-1:0]          e_start_x,
  input  logic signed [COORD_BITS-1:0]          e_start_y,
  input  logic        [COORD_BITS-1:0]          e_major_len,
  input  logic        [COORD_BITS-1:0]          e_minor_len,
  input  logic                                  e_step_x_neg,
  input  logic                                  e_step_y_neg,
  input  logic                                  e_x_is_major,
  input  logic        [lrc_pkg::COLOR_BITS-1:0] e_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_BITS:0]            pixel_x,
  output logic signed [COORD_BITS:0]            pixel_y,
  output logic        [lrc_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                                  drawn,
  output logic                                  last
);
  import lrc_pkg::*;

  localparam int POS_BITS = COORD_BITS + 1;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int CMP_BITS = (POS_BITS > WIN_BITS + 1) ? POS_BITS : WIN_BITS + 1;

  logic signed [POS_BITS-1:0]   pos_x;
  logic signed [POS_BITS-1:0]   pos_y;
  logic        [ERR_BITS-1:0]   error_term;
  logic        [COORD_BITS-1:0] major_len;
  logic        [COORD_BITS-1:0] minor_len;
  logic        [COORD_BITS-1:0] steps_left;
  logic                         step_x_neg;
  logic                         step_y_neg;
  logic                         x_is_major;
  logic        [COLOR_BITS-1:0] held_color;
  logic                         active;

  logic        [ERR_BITS-1:0]   err_sum;
  logic        [ERR_BITS-1:0]   twice_major;
  logic                         carry;
  logic        [ERR_BITS-1:0]   error_next;
  logic signed [POS_BITS-1:0]   pos_x_next;
  logic signed [POS_BITS-1:0]   pos_y_next;
  logic signed [CMP_BITS-1:0]   x_wide;
  logic signed [CMP_BITS-1:0]   y_wide;
  logic signed [CMP_BITS-1:0]   width_wide;
  logic signed [CMP_BITS-1:0]   height_wide;
  logic                         leave;
  logic        [COORD_BITS-1:0] steps_next;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    err_sum     = error_term + {2'b00, minor_len, 1'b0};
    twice_major = {2'b00, major_len, 1'b0};
    carry       = err_sum >= twice_major;
    error_next  = carry ? err_sum - twice_major : err_sum;

    // The major axis moves every step, the minor one only on an error carry.
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    if (x_is_major || carry) begin
      pos_x_next = step_x_neg ? pos_x - POS_BITS'(1) : pos_x + POS_BITS'(1);
    end
    if (!x_is_major || carry) begin
      pos_y_next = step_y_neg ? pos_y - POS_BITS'(1) : pos_y + POS_BITS'(1);
    end

    x_wide      = CMP_BITS'(pos_x_next);
    y_wide      = CMP_BITS'(pos_y_next);
    width_wide  = signed'({{(CMP_BITS - WIN_BITS){1'b0}}, win.width});
    height_wide = signed'({{(CMP_BITS - WIN_BITS){1'b0}}, win.height});

    // Only the side the line is heading toward is tested on each axis.
    leave = (!step_x_neg && (x_wide >= width_wide))  ||
            ( step_x_neg && pos_x_next[POS_BITS-1])  ||
            ( step_y_neg && pos_y_next[POS_BITS-1])  ||
            (!step_y_neg && (y_wide >= height_wide));

    steps_next = steps_left - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (q_pop) begin
      if (e_load) begin
        pos_x      <= POS_BITS'(e_start_x);
        pos_y      <= POS_BITS'(e_start_y);
        error_term <= ERR_BITS'(e_major_len);
        major_len  <= e_major_len;
        minor_len  <= e_minor_len;
        steps_left <= e_major_len;
        step_x_neg <= e_step_x_neg;
        step_y_neg <= e_step_y_neg;
        x_is_major <= e_x_is_major;
        held_color <= e_color;
        active     <= (e_major_len != '0);
        out_valid  <= 1'b0;
      end else if (active) begin
        pos_x      <= pos_x_next;
        pos_y      <= pos_y_next;
        error_term <= error_next;
        out_valid  <= 1'b1;
        last       <= leave || (steps_next == '0);
        if (leave) begin
          active      <= 1'b0;
          steps_left  <= '0;
          pixel_x     <= '0;
          pixel_y     <= '0;
          pixel_color <= '0;
          drawn       <= 1'b0;
        end else begin
          active      <= (steps_next != '0);
          steps_left  <= steps_next;
          pixel_x     <= pos_x_next;
          pixel_y     <= pos_y_next;
          pixel_color <= held_color;
          drawn       <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/lrc_checker.sv @@
// Port-level checks for the line rasterizer, bound to line_rasterizer_clipped.
// Uses lrc_pkg for port widths.
module lrc_checker #(
  parameter int COORD_BITS = 13
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [COORD_BITS:0]            pixel_x,
  input logic signed [COORD_BITS:0]            pixel_y,
  input logic        [lrc_pkg::COLOR_BITS-1:0] pixel_color,
  input logic                                  drawn,
  input logic                                  last
);
  import lrc_pkg::*;

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
                               $stable(pixel_color) && $stable(drawn) && $stable(last))
    else $error("stalled result changed");

  // An end marker for leaving the window closes the line and carries zeros.
  a_exit_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drawn |-> last && (pixel_x == '0) && (pixel_y == '0) &&
                            (pixel_color == '0))
    else $error("window exit result malformed");

  // Reset leaves no result on the output and the input unstalled.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // The input side can only fill up through transfers into it.
  a_stall_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !in_stall)
    else $error("in_stall rose without an input transfer");

endmodule

bind line_rasterizer_clipped lrc_checker #(.COORD_BITS(COORD_BITS)) u_lrc_checker (.*);
